### design/iff_pkg.sv
// Package for the integer field formatter: types, codes, ASCII constants
// and the digit-to-character function. No dependencies.

package iff_pkg;

  localparam int VALUE_W = 32;
  localparam int DIG_W   = 40;  // ten BCD nibbles, also holds eight hex nibbles
  localparam int NDIG_W  = 4;
  localparam int DD_CNT_W = 5;  // one double-dabble step per value bit

  localparam logic [NDIG_W-1:0] DEC_DIGITS = 4'd10;
  localparam logic [NDIG_W-1:0] HEX_DIGITS = 4'd8;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEXU = 2'd2,
    MODE_HEXL = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_SIGN_LEAD,
    S_PAD,
    S_SIGN_MID,
    S_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dd_step;
    logic shift_step;
  } dig_ctrl_t;

  typedef struct packed {
    logic              dd_last;
    logic              norm_done;
    logic              neg;
    logic [NDIG_W-1:0] ndig;
    logic [3:0]        top_nib;
  } dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic lower);
    logic [7:0] letter_base;
    letter_base = lower ? CH_LOWER_A : CH_UPPER_A;
    if (nib < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, nib};
    end else begin
      digit_char = letter_base + {4'd0, nib} - 8'd10;
    end
  endfunction

endpackage

### design/iff_if.sv
// Channel interfaces of the integer field formatter: the request channel
// and the character channel. Depends on nothing.

interface iff_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  mode;
  logic [7:0]  min_width;
  logic        zero_fill;

  modport source (output valid, value, mode, min_width, zero_fill, input ready);
  modport sink   (input valid, value, mode, min_width, zero_fill, output ready);
endinterface

interface iff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

### design/iff_digits.sv
// Digit register of the formatter: magnitude, shared shift-add-3 unit for
// binary to BCD, and the nibble shifter used for normalizing and emitting.
// Depends on iff_pkg.

module iff_digits (
  input  logic                          clk,
  input  logic [iff_pkg::VALUE_W-1:0]   value,
  input  logic [1:0]                    mode,
  input  iff_pkg::dig_ctrl_t            ctrl,
  output iff_pkg::dig_stat_t            stat
);

  logic [iff_pkg::VALUE_W-1:0]  bin;
  logic [iff_pkg::DIG_W-1:0]    dig;
  logic [iff_pkg::DIG_W-1:0]    adj;
  logic [iff_pkg::NDIG_W-1:0]   ndig;
  logic [iff_pkg::DD_CNT_W-1:0] dd_cnt;
  logic                         neg;
  logic                         is_neg;
  logic                         is_hex;

  assign is_hex = mode[1];
  assign is_neg = (iff_pkg::mode_t'(mode) == iff_pkg::MODE_SDEC) && value[iff_pkg::VALUE_W-1];

  // add 3 to every BCD digit of 5 or more before the shift
  for (genvar i = 0; i < iff_pkg::DIG_W / 4; i++) begin : g_adj
    assign adj[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3 : dig[4*i +: 4];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg    <= is_neg;
      dd_cnt <= '0;
      if (is_hex) begin
        bin  <= value;
        dig  <= {value, 8'h00};
        ndig <= iff_pkg::HEX_DIGITS;
      end else begin
        bin  <= is_neg ? (~value + 32'd1) : value;
        dig  <= '0;
        ndig <= iff_pkg::DEC_DIGITS;
      end
    end else if (ctrl.dd_step) begin
      bin    <= {bin[iff_pkg::VALUE_W-2:0], 1'b0};
      dig    <= {adj[iff_pkg::DIG_W-2:0], bin[iff_pkg::VALUE_W-1]};
      dd_cnt <= dd_cnt + 5'd1;
    end else if (ctrl.shift_step) begin
      dig  <= {dig[iff_pkg::DIG_W-5:0], 4'h0};
      ndig <= ndig - 4'd1;
    end
  end

  assign stat.dd_last   = (dd_cnt == 5'd31);
  assign stat.top_nib   = dig[iff_pkg::DIG_W-1 -: 4];
  assign stat.norm_done = (ndig == 4'd1) || (dig[iff_pkg::DIG_W-1 -: 4] != 4'h0);
  assign stat.neg       = neg;
  assign stat.ndig      = ndig;

endmodule

### design/integer_field_formatter.sv
// Top level of the integer field formatter: sequencer, padding count and
// output register. Depends on iff_pkg, iff_if.sv and iff_digits.
//
//  channel  dir  payload                               transfer when
//  -------  ---  ------------------------------------  ------------------
//  field    in   value, mode, min_width, zero_fill     valid && ready
//  text     out  out_char, last                        valid && ready
//
// Decimal: a load step, the shift-add-3 steps of the shared unit in
// iff_digits, the normalize steps, a pad-check step, then the characters
// (max 25). Hex: load, normalize steps, pad-check step, then characters.
// field.ready is high only while idle; a finished character waits in the
// output register, and the sequencer stalls while that register is full
// and text.ready is low.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.

module integer_field_formatter (
  input logic       clk,
  input logic       rst,
  iff_in_if.sink    field,
  iff_out_if.source text
);

  iff_pkg::state_t    state;
  iff_pkg::state_t    state_next;
  iff_pkg::dig_ctrl_t ctrl;
  iff_pkg::dig_stat_t stat;

  logic [7:0] width;     // captured min_width
  logic       zf;        // captured zero_fill
  logic       lower;     // lower-case hex
  logic [3:0] pad_cnt;   // fill characters still to send
  logic [3:0] pad_calc;
  logic [9:0] pad_t;     // min_width - digits - sign, two's complement

  logic       emit_ok;
  logic       char_load;
  logic [7:0] char_val;
  logic       char_last;

  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  iff_digits u_digits (
    .clk   (clk),
    .value (field.value),
    .mode  (field.mode),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // padding: c - 1 fills when c is 2..15, i.e. pad_t in 1..14
  assign pad_t    = {2'b00, width} - {6'd0, stat.ndig} - {9'd0, stat.neg};
  assign pad_calc = (!pad_t[9] && pad_t != 10'd0 && pad_t <= 10'd14) ? pad_t[3:0] : 4'd0;

  // output register frees when empty or being taken
  assign emit_ok = !out_valid || text.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iff_pkg::S_IDLE: begin
        if (field.valid) begin
          state_next = field.mode[1] ? iff_pkg::S_NORM : iff_pkg::S_CONV;
        end
      end
      iff_pkg::S_CONV: begin
        if (stat.dd_last) state_next = iff_pkg::S_NORM;
      end
      iff_pkg::S_NORM: begin
        if (stat.norm_done) begin
          state_next = (stat.neg && zf) ? iff_pkg::S_SIGN_LEAD : iff_pkg::S_PAD;
        end
      end
      iff_pkg::S_SIGN_LEAD: begin
        if (emit_ok) state_next = iff_pkg::S_PAD;
      end
      iff_pkg::S_PAD: begin
        if (pad_cnt == 4'd0) begin
          state_next = (stat.neg && !zf) ? iff_pkg::S_SIGN_MID : iff_pkg::S_DIGIT;
        end
      end
      iff_pkg::S_SIGN_MID: begin
        if (emit_ok) state_next = iff_pkg::S_DIGIT;
      end
      iff_pkg::S_DIGIT: begin
        if (emit_ok && stat.ndig == 4'd1) state_next = iff_pkg::S_IDLE;
      end
      default: state_next = iff_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl      = '0;
    char_load = 1'b0;
    char_val  = iff_pkg::CH_SPACE;
    char_last = 1'b0;
    unique case (state)
      iff_pkg::S_IDLE:  ctrl.load = field.valid;
      iff_pkg::S_CONV:  ctrl.dd_step = 1'b1;
      iff_pkg::S_NORM:  ctrl.shift_step = !stat.norm_done;
      iff_pkg::S_SIGN_LEAD: begin
        char_load = emit_ok;
        char_val  = iff_pkg::CH_MINUS;
      end
      iff_pkg::S_PAD: begin
        char_load = emit_ok && (pad_cnt != 4'd0);
        char_val  = zf ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
      end
      iff_pkg::S_SIGN_MID: begin
        char_load = emit_ok;
        char_val  = iff_pkg::CH_MINUS;
      end
      iff_pkg::S_DIGIT: begin
        char_load       = emit_ok;
        char_val        = iff_pkg::digit_char(stat.top_nib, lower);
        char_last       = (stat.ndig == 4'd1);
        ctrl.shift_step = emit_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iff_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request fields and pad count
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      width <= field.min_width;
      zf    <= field.zero_fill;
      lower <= (iff_pkg::mode_t'(field.mode) == iff_pkg::MODE_HEXL);
    end
    if (state == iff_pkg::S_NORM && stat.norm_done) begin
      pad_cnt <= pad_calc;
    end else if (state == iff_pkg::S_PAD && char_load) begin
      pad_cnt <= pad_cnt - 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (char_load) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_load) begin
      out_char <= char_val;
      out_last <= char_last;
    end
  end

  assign field.ready   = (state == iff_pkg::S_IDLE);
  assign text.valid    = out_valid;
  assign text.out_char = out_char;
  assign text.last     = out_last;

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    field.valid && field.ready |=> !field.ready)
    else $error("request taken while a field is in progress");

  a_ndig_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == iff_pkg::S_NORM || state == iff_pkg::S_DIGIT) |-> stat.ndig != 4'd0)
    else $error("digit count ran out");

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    state == iff_pkg::S_PAD |-> pad_cnt <= 4'd14)
    else $error("pad count out of range");

  a_last_ends_field: assert property (@(posedge clk) disable iff (rst)
    char_load && char_last |=> state == iff_pkg::S_IDLE)
    else $error("sequencer still busy after last character");

endmodule

### tb/tb_top.sv
// Testbench for integer_field_formatter: random and directed integer fields,
// with the expected character stream checked against an in-bench formatter.
// Depends on iff_pkg, the channel interfaces in iff_if.sv and the RTL top.

module tb_top;

  localparam int RANDOM_REQUESTS   = 336;
  localparam int QUIET_TAIL        = 40;     // last requests run with no idling
  localparam int LONG_HOLD_AT      = 90;     // request count that starts the long stall
  localparam int LONG_HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES     = 150;    // > one field's conversion + 25 chars
  localparam int CYCLE_LIMIT       = 400000;
  localparam int PRINT_MAX         = 50;

  localparam logic [7:0] ASCII_ZERO  = "0";
  localparam logic [7:0] ASCII_SPACE = " ";
  localparam logic [7:0] ASCII_MINUS = "-";

  // One conversion request, plus a flag that holds it back until the text
  // channel has delivered everything expected so far.
  typedef struct {
    logic [31:0]     value;
    iff_pkg::mode_t  mode;
    logic [7:0]      min_width;
    logic            zero_fill;
    bit              drain_first;
  } format_request_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst;

  iff_in_if  field_ch ();
  iff_out_if text_ch ();

  integer_field_formatter dut (
    .clk   (clk),
    .rst   (rst),
    .field (field_ch),
    .text  (text_ch)
  );

  format_request_t requests_to_send[$];
  text_char_t      expected_chars[$];
  text_char_t      want_char;

  int  requests_taken = 0;
  int  total_requests = 0;
  int  char_errors    = 0;
  int  cycle_count    = 0;
  int  send_gap       = 0;
  int  recv_gap       = 0;
  int  hold_left      = 0;
  bit  long_hold_done = 1'b0;
  logic quiet_tail;

  assign quiet_tail = (requests_taken >= total_requests - QUIET_TAIL);

  // Clock: period 4.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Failure report: one line per mismatch, printing capped, counting not.
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (char_errors < PRINT_MAX) begin
      $display("tb: mismatch on %s after %0d requests: got %02h, want %02h",
               what, requests_taken, got, want);
    end
    char_errors++;
  endtask

  // Expected character stream for one request.
  // Digits are produced least significant first and then reversed by pushing
  // to the front. Padding follows the printf-like rule of this block:
  // spare = width - (digits - 1) - sign; pad spare-1 fill chars when spare
  // lies in 2..15, nothing otherwise. Zero fill puts the sign before the
  // padding, space fill puts it right before the digits.
  function automatic void format_field(format_request_t req);
    logic [31:0] magnitude;
    logic [31:0] radix;
    logic [7:0]  letter_a;
    logic [3:0]  nib;
    logic        negative;
    logic [7:0]  digit_text[$];
    logic [7:0]  field_text[$];
    int          spare;
    negative  = (req.mode == iff_pkg::MODE_SDEC) && req.value[31];
    // two's complement negate; 0x80000000 stays 0x80000000 = 2147483648
    magnitude = negative ? (32'd0 - req.value) : req.value;
    radix     = (req.mode == iff_pkg::MODE_HEXU || req.mode == iff_pkg::MODE_HEXL)
                ? 32'd16 : 32'd10;
    letter_a  = (req.mode == iff_pkg::MODE_HEXL) ? "a" : "A";
    do begin
      nib = 4'(magnitude % radix);
      digit_text.push_front((nib < 4'd10) ? ASCII_ZERO + {4'd0, nib}
                                          : letter_a + {4'd0, nib} - 8'd10);
      magnitude = magnitude / radix;
    end while (magnitude != 32'd0);
    spare = int'(req.min_width) - (digit_text.size() - 1) - (negative ? 1 : 0);
    if (negative && req.zero_fill) begin
      field_text.push_back(ASCII_MINUS);
    end
    if (spare >= 2 && spare <= 15) begin
      repeat (spare - 1) field_text.push_back(req.zero_fill ? ASCII_ZERO : ASCII_SPACE);
    end
    if (negative && !req.zero_fill) begin
      field_text.push_back(ASCII_MINUS);
    end
    foreach (digit_text[i]) field_text.push_back(digit_text[i]);
    foreach (field_text[i]) begin
      expected_chars.push_back('{ch: field_text[i], last: (i == field_text.size() - 1)});
    end
  endfunction

  task automatic add_request(logic [31:0] value, iff_pkg::mode_t mode,
                             logic [7:0] min_width, logic zero_fill, bit drain_first);
    format_request_t req;
    req.value       = value;
    req.mode        = mode;
    req.min_width   = min_width;
    req.zero_fill   = zero_fill;
    req.drain_first = drain_first;
    requests_to_send.push_back(req);
  endtask

  // Field side driver. The front of requests_to_send is what is on offer;
  // it is popped and predicted on the transfer edge. An offer that is not
  // yet taken is held unchanged.
  always @(posedge clk) begin
    if (rst) begin
      field_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (field_ch.valid && field_ch.ready) begin
        format_field(requests_to_send.pop_front());
        requests_taken++;
      end
      if (field_ch.valid && !field_ch.ready) begin
        // offer stays up until the block takes it
      end else if (send_gap > 0) begin
        send_gap--;
        field_ch.valid <= 1'b0;
      end else if (requests_to_send.size() == 0 ||
                   (requests_to_send[0].drain_first && expected_chars.size() != 0)) begin
        // nothing left, or pausing until every expected char is out
        field_ch.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        field_ch.valid <= 1'b0;
      end else begin
        field_ch.valid     <= 1'b1;
        field_ch.value     <= requests_to_send[0].value;
        field_ch.mode      <= requests_to_send[0].mode;
        field_ch.min_width <= requests_to_send[0].min_width;
        field_ch.zero_fill <= requests_to_send[0].zero_fill;
      end
    end
  end

  // Text side: checks each transfer against the oldest expected char and
  // drives ready. One long stall is taken partway through the run while the
  // driver keeps offering, so the block backs up and drops field.ready.
  always @(posedge clk) begin
    if (rst) begin
      text_ch.ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected char", text_ch.out_char, 8'h00);
        end else begin
          want_char = expected_chars.pop_front();
          if (text_ch.out_char !== want_char.ch) begin
            report_mismatch("out_char", text_ch.out_char, want_char.ch);
          end
          if (text_ch.last !== want_char.last) begin
            report_mismatch("last", {7'd0, text_ch.last}, {7'd0, want_char.last});
          end
        end
      end
      if (!long_hold_done && requests_taken >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        text_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        text_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 2);
        text_ch.ready <= 1'b0;
      end else begin
        text_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus set-up, reset and end of run.
  initial begin
    format_request_t req;
    logic [31:0]     raw;
    rst                = 1'b1;
    field_ch.valid     = 1'b0;
    field_ch.value     = 32'd0;
    field_ch.mode      = iff_pkg::MODE_SDEC;
    field_ch.min_width = 8'd0;
    field_ch.zero_fill = 1'b0;
    text_ch.ready      = 1'b0;

    // Directed: all ones in each mode, zero in two modes, the most negative
    // value in all modes but upper hex, sign placement with both fills,
    // padding edges at spare 1, 2, 15, 16, and the widest field (25 chars).
    add_request(32'h0000_0000, iff_pkg::MODE_SDEC, 8'd0,   1'b0, 1'b0);
    add_request(32'h0000_0000, iff_pkg::MODE_HEXL, 8'd255, 1'b1, 1'b0);
    add_request(32'hFFFF_FFFF, iff_pkg::MODE_UDEC, 8'd0,   1'b0, 1'b0);
    add_request(32'hFFFF_FFFF, iff_pkg::MODE_SDEC, 8'd0,   1'b0, 1'b0);
    add_request(32'hFFFF_FFFF, iff_pkg::MODE_HEXU, 8'd0,   1'b0, 1'b0);
    add_request(32'hFFFF_FFFF, iff_pkg::MODE_HEXL, 8'd8,   1'b1, 1'b0);
    add_request(32'h8000_0000, iff_pkg::MODE_SDEC, 8'd0,   1'b0, 1'b0);
    add_request(32'h8000_0000, iff_pkg::MODE_SDEC, 8'd15,  1'b1, 1'b0);
    add_request(32'h7FFF_FFFF, iff_pkg::MODE_SDEC, 8'd0,   1'b0, 1'b0);
    add_request(32'hFFFF_FF85, iff_pkg::MODE_SDEC, 8'd6,   1'b0, 1'b0);  // -123, spaces, sign
    add_request(32'hFFFF_FF85, iff_pkg::MODE_SDEC, 8'd6,   1'b1, 1'b0);  // -123, sign, zeros
    add_request(32'd5,         iff_pkg::MODE_UDEC, 8'd2,   1'b1, 1'b0);
    add_request(32'd5,         iff_pkg::MODE_UDEC, 8'd1,   1'b0, 1'b0);
    add_request(32'd5,         iff_pkg::MODE_UDEC, 8'd15,  1'b0, 1'b0);
    add_request(32'd5,         iff_pkg::MODE_UDEC, 8'd16,  1'b1, 1'b0);
    add_request(32'hABCD_EF01, iff_pkg::MODE_HEXU, 8'd12,  1'b1, 1'b0);
    add_request(32'h00C0_FFEE, iff_pkg::MODE_HEXL, 8'd10,  1'b0, 1'b0);
    add_request(32'd60,        iff_pkg::MODE_SDEC, 8'd255, 1'b1, 1'b0);
    add_request(32'd1,         iff_pkg::MODE_SDEC, 8'd16,  1'b0, 1'b0);
    add_request(32'hFFFF_FFFF, iff_pkg::MODE_SDEC, 8'd3,   1'b1, 1'b0);
    add_request(32'd1000000000, iff_pkg::MODE_UDEC, 8'd25, 1'b0, 1'b0);
    add_request(32'h8000_0000, iff_pkg::MODE_SDEC, 8'd25,  1'b0, 1'b0);
    add_request(32'h8000_0000, iff_pkg::MODE_SDEC, 8'd25,  1'b1, 1'b0);
    add_request(32'h8000_0000, iff_pkg::MODE_HEXL, 8'd0,   1'b0, 1'b0);
    add_request(32'h8000_0000, iff_pkg::MODE_UDEC, 8'd0,   1'b0, 1'b0);

    // Random: values of every magnitude (and their complements, to get small
    // negatives), widths mostly near the digit count, sometimes anywhere.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      raw = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 2) == 0) begin
        raw = ~raw;
      end
      req.value       = raw;
      req.mode        = iff_pkg::mode_t'($urandom_range(0, 3));
      req.min_width   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 26));
      req.zero_fill   = 1'($urandom_range(0, 1));
      req.drain_first = (n == 0 || n == RANDOM_REQUESTS / 2);
      requests_to_send.push_back(req);
    end
    total_requests = requests_to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (requests_to_send.size() != 0 || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    // let any stray char show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch("missing chars", 8'(expected_chars.size()), 8'h00);
    end

    if (char_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
